// ===== hw/rtl/divided_difference_interpolator_macros.svh =====
// Assertion helpers
`ifndef DIVIDED_DIFFERENCE_INTERPOLATOR_MACROS_SVH
`define DIVIDED_DIFFERENCE_INTERPOLATOR_MACROS_SVH

`define DDI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define DDI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ddi_pkg.sv =====
`timescale 1ns / 1ps

package ddi_pkg;

    localparam int DDI_MAX_POINTS = 8;
    localparam int DDI_FRAC_BITS  = 16;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_EVAL   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_DUP   = 3'd3,
        ST_SAT   = 3'd4
    } ddi_status_t;

    // 33-bit signed to 32-bit with saturation; bit 32 of the result is the sat flag
    function automatic logic [32:0] ddi_clamp33(input logic signed [32:0] v);
        logic [32:0] r;
        if (v[32] != v[31])
        begin
            r = {1'b1, v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/divided_difference_interpolator.sv =====
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                   | tuser
// s_*     | in  | x_value[31:0], y_value[31:0]         | req_type[1:0]
// m_*     | out | interp_value[31:0], point_count[3:0] | status[2:0]
// Evaluate uses a radix-2 divider for the divided differences.
// Reset clears the point count and the handshakes; the stores need no clearing.
// One item at a time; the next is taken while a result waits in the output register.
`include "divided_difference_interpolator_macros.svh"

module divided_difference_interpolator
    import ddi_pkg::*;
#(
    parameter int MAX_POINTS = DDI_MAX_POINTS,
    parameter int FRAC_BITS  = DDI_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x_value, y_value
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // interp_value, point_count, zero pad
    output logic [2:0]  m_tuser    // status
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int QW = 33 + FRAC_BITS;
    localparam int KW = $clog2(QW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CPRD, S_CPWR, S_RD, S_SUB, S_DIV, S_WB,
        S_TRD, S_TMUL, S_TACC, S_PMUL, S_PSC, S_FIN
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      i_reg;
    logic [AW-1:0]      j_reg;
    logic [31:0]        q_reg;
    logic [31:0]        acc_reg;
    logic [31:0]        prod_reg;
    logic [31:0]        fac_reg;
    logic               fac_sat_reg;
    logic               sat_reg;
    logic signed [63:0] mul_reg;
    logic [32:0]        rem_reg;
    logic [QW-1:0]      quo_reg;
    logic [32:0]        den_mag_reg;
    logic               neg_reg;
    logic [KW-1:0]      cnt_reg;
    logic [31:0]        res_val_reg;
    ddi_status_t        res_st_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_val_reg;
    logic [2:0]         m_st_reg;
    logic [3:0]         m_cnt_reg;

    // point store: {y, x}
    logic [63:0] pt_mem [MAX_POINTS];
    logic [31:0] dt_mem [MAX_POINTS];
    logic [31:0] xa_reg;
    logic [31:0] xb_reg;
    logic [31:0] ya_reg;
    logic [31:0] da_reg;
    logic [31:0] db_reg;

    logic               accept;
    logic               not_full;
    logic [AW-1:0]      ra0;
    logic [AW-1:0]      ra1_d;
    logic [AW-1:0]      ra1_x;
    logic               dt_we;
    logic [31:0]        dt_wd;
    logic signed [32:0] num_w;
    logic signed [32:0] den_w;
    logic [32:0]        num_mag;
    logic [32:0]        den_mag;
    logic [32:0]        fac_w;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] rnd_w;
    logic signed [63:0] shf_w;
    logic               scl_sat;
    logic [31:0]        scl_val;
    logic [32:0]        acc_w;
    logic [33:0]        trial;
    logic               ge;
    logic [32:0]        rem_n;
    logic               div_sat;
    logic [31:0]        div_val;
    logic               more_terms;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign not_full = (count_reg < CW'(MAX_POINTS));

    assign ra0   = (state_reg == S_TRD) ? j_reg : i_reg;
    assign ra1_d = i_reg - AW'(1);
    assign ra1_x = i_reg - j_reg;
    assign dt_we = (state_reg == S_CPWR) || (state_reg == S_WB);
    assign dt_wd = (state_reg == S_CPWR) ? ya_reg : div_val;

    always_ff @(posedge clk)
    begin
        if (accept && s_tuser == REQ_APPEND && not_full)
        begin
            pt_mem[count_reg[AW-1:0]] <= s_tdata;
        end
        if (dt_we)
        begin
            dt_mem[i_reg] <= dt_wd;
        end
        xa_reg <= pt_mem[ra0][31:0];
        xb_reg <= pt_mem[ra1_x][31:0];
        ya_reg <= pt_mem[ra0][63:32];
        da_reg <= dt_mem[ra0];
        db_reg <= dt_mem[ra1_d];
    end

    assign num_w   = $signed({da_reg[31], da_reg}) - $signed({db_reg[31], db_reg});
    assign den_w   = $signed({xa_reg[31], xa_reg}) - $signed({xb_reg[31], xb_reg});
    assign num_mag = num_w[32] ? 33'(-num_w) : 33'(num_w);
    assign den_mag = den_w[32] ? 33'(-den_w) : 33'(den_w);
    assign fac_w   = ddi_clamp33($signed({q_reg[31], q_reg}) - $signed({xa_reg[31], xa_reg}));

    assign mul_a = (state_reg == S_TMUL) ? $signed(da_reg) : $signed(prod_reg);
    assign mul_b = (state_reg == S_TMUL) ? $signed(prod_reg) : $signed(fac_reg);

    // truncate toward zero, then saturate
    assign rnd_w   = mul_reg + (mul_reg[63] ? $signed(64'((64'd1 << FRAC_BITS) - 64'd1))
                                            : 64'sd0);
    assign shf_w   = rnd_w >>> FRAC_BITS;
    assign scl_sat = (shf_w[63:31] != {33{1'b0}}) && (shf_w[63:31] != {33{1'b1}});
    assign scl_val = scl_sat ? (shf_w[63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : shf_w[31:0];
    assign acc_w   = ddi_clamp33($signed({acc_reg[31], acc_reg})
                               + $signed({scl_val[31], scl_val}));

    assign trial = {rem_reg, quo_reg[QW-1]};
    assign ge    = (trial >= {1'b0, den_mag_reg});
    assign rem_n = ge ? 33'(trial - {1'b0, den_mag_reg}) : trial[32:0];

    assign div_sat = neg_reg ? (quo_reg > (QW'(1) << 31)) : (quo_reg > QW'(32'h7FFF_FFFF));
    assign div_val = div_sat ? (neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF)
                             : (neg_reg ? 32'(-quo_reg[31:0]) : quo_reg[31:0]);

    assign more_terms = ((CW'(j_reg) + CW'(1)) < count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && state_reg != S_FIN)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_val_reg <= '0;
                        res_st_reg  <= ST_OK;
                        state_reg   <= S_FIN;
                        unique case (s_tuser)
                            REQ_APPEND:
                            begin
                                if (not_full)
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                                else
                                begin
                                    res_st_reg <= ST_FULL;
                                end
                            end
                            REQ_EVAL:
                            begin
                                q_reg    <= s_tdata[31:0];
                                i_reg    <= '0;
                                j_reg    <= '0;
                                acc_reg  <= '0;
                                prod_reg <= 32'(64'd1 << FRAC_BITS);
                                sat_reg  <= 1'b0;
                                if (count_reg == '0)
                                begin
                                    res_st_reg <= ST_EMPTY;
                                end
                                else
                                begin
                                    state_reg <= S_CPRD;
                                end
                            end
                            REQ_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_CPRD:
                begin
                    state_reg <= S_CPWR;
                end
                S_CPWR:
                begin
                    if (CW'(i_reg) == count_reg - CW'(1))
                    begin
                        state_reg <= S_TRD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + AW'(1);
                        state_reg <= S_CPRD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_SUB;
                end
                S_SUB:
                begin
                    if (den_w == '0)
                    begin
                        res_val_reg <= '0;
                        res_st_reg  <= ST_DUP;
                        state_reg   <= S_FIN;
                    end
                    else
                    begin
                        rem_reg     <= '0;
                        quo_reg     <= {num_mag, {FRAC_BITS{1'b0}}};
                        den_mag_reg <= den_mag;
                        neg_reg     <= num_w[32] ^ den_w[32];
                        cnt_reg     <= KW'(QW);
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_n;
                    quo_reg <= {quo_reg[QW-2:0], ge};
                    cnt_reg <= cnt_reg - KW'(1);
                    if (cnt_reg == KW'(1))
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    sat_reg <= sat_reg | div_sat;
                    if (i_reg == j_reg)
                    begin
                        state_reg <= S_TRD;
                    end
                    else
                    begin
                        i_reg     <= i_reg - AW'(1);
                        state_reg <= S_RD;
                    end
                end
                S_TRD:
                begin
                    state_reg <= S_TMUL;
                end
                S_TMUL:
                begin
                    mul_reg     <= mul_a * mul_b;
                    fac_reg     <= fac_w[31:0];
                    fac_sat_reg <= fac_w[32];
                    state_reg   <= S_TACC;
                end
                S_TACC:
                begin
                    acc_reg <= acc_w[31:0];
                    sat_reg <= sat_reg | scl_sat | acc_w[32];
                    if (more_terms)
                    begin
                        state_reg <= S_PMUL;
                    end
                    else
                    begin
                        res_val_reg <= acc_w[31:0];
                        res_st_reg  <= (sat_reg | scl_sat | acc_w[32]) ? ST_SAT : ST_OK;
                        state_reg   <= S_FIN;
                    end
                end
                S_PMUL:
                begin
                    mul_reg   <= mul_a * mul_b;
                    sat_reg   <= sat_reg | fac_sat_reg;
                    state_reg <= S_PSC;
                end
                S_PSC:
                begin
                    prod_reg  <= scl_val;
                    sat_reg   <= sat_reg | scl_sat;
                    j_reg     <= j_reg + AW'(1);
                    i_reg     <= AW'(count_reg - CW'(1));
                    state_reg <= S_RD;
                end
                S_FIN:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_val_reg    <= res_val_reg;
                        m_st_reg     <= res_st_reg;
                        m_cnt_reg    <= 4'(count_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, m_cnt_reg, m_val_reg};
    assign m_tuser  = m_st_reg;

    `DDI_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CW'(MAX_POINTS), "point count overflow")
    `DDI_ASSERT_IMPL(a_div_nonzero, state_reg == S_DIV, den_mag_reg != '0, "divide by zero")
    `DDI_ASSERT_IMPL(a_rd_index, state_reg == S_RD, (i_reg >= j_reg) && (j_reg != '0), "bad index")
    `DDI_ASSERT_NEXT(a_dup_zero, state_reg == S_FIN && res_st_reg == ST_DUP && m_tvalid_reg == 1'b0,
        m_tvalid_reg && m_val_reg == '0, "duplicate abscissa with nonzero value")

endmodule

// ===== test/ddi_checker.sv =====
`timescale 1ns / 1ps

module ddi_checker
    import ddi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          fail_count,
    output int          pending,
    output int          words_checked,
    output int          evals_checked,
    output int          sat_seen,
    output int          dup_seen
);

    typedef struct packed {
        logic [31:0] interp_value;
        ddi_status_t status;
        logic [3:0]  point_count;
    } ddi_result_t;

    ddi_result_t expected_results[$];

    longint abscissa[DDI_MAX_POINTS];
    longint ordinate[DDI_MAX_POINTS];
    longint diff_tbl[DDI_MAX_POINTS];
    int     num_points;
    bit     sat_flag;

    localparam longint ONE = longint'(1) << DDI_FRAC_BITS;

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
        begin
            sat_flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat_flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint fixed_mul(input longint a, input longint b);
        return sat32((a * b) / ONE);
    endfunction

    function automatic ddi_status_t newton_eval(input longint q, output longint value);
        longint acc;
        longint prod;
        longint num;
        longint den;
        sat_flag = 1'b0;
        acc      = 0;
        prod     = ONE;
        value    = 0;
        if (num_points == 0)
            return ST_EMPTY;
        for (int j = 0; j < num_points; j++)
        begin
            for (int i = num_points - 1; i >= j; i--)
            begin
                if (j == 0)
                    diff_tbl[i] = ordinate[i];
                else
                begin
                    num = diff_tbl[i] - diff_tbl[i-1];
                    den = abscissa[i] - abscissa[i-j];
                    if (den == 0)
                        return ST_DUP;
                    diff_tbl[i] = sat32((num * ONE) / den);
                end
            end
            acc = sat32(acc + fixed_mul(diff_tbl[j], prod));
            if (j + 1 < num_points)
                prod = fixed_mul(prod, sat32(q - abscissa[j]));
        end
        value = acc;
        return sat_flag ? ST_SAT : ST_OK;
    endfunction

    function automatic ddi_result_t predict_word(input logic [1:0] req,
                                                 input logic [31:0] x,
                                                 input logic [31:0] y);
        ddi_result_t r;
        longint      value;
        value = 0;
        r.status = ST_OK;
        case (req)
            REQ_APPEND:
            begin
                if (num_points >= DDI_MAX_POINTS)
                    r.status = ST_FULL;
                else
                begin
                    abscissa[num_points] = longint'($signed(x));
                    ordinate[num_points] = longint'($signed(y));
                    num_points++;
                end
            end
            REQ_EVAL:  r.status = newton_eval(longint'($signed(x)), value);
            REQ_CLEAR: num_points = 0;
            default: ;
        endcase
        r.interp_value = value[31:0];
        r.point_count  = num_points[3:0];
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        fail_count++;
    endtask

    assign pending = expected_results.size();

    initial
    begin
        fail_count    = 0;
        words_checked = 0;
        evals_checked = 0;
        sat_seen      = 0;
        dup_seen      = 0;
        num_points    = 0;
    end

    always @(posedge clk)
    begin
        ddi_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                want = predict_word(s_tuser, s_tdata[31:0], s_tdata[63:32]);
                if (s_tuser == REQ_EVAL)
                    evals_checked++;
                if (want.status == ST_SAT)
                    sat_seen++;
                if (want.status == ST_DUP)
                    dup_seen++;
                expected_results.insert(expected_results.size(), want);
            end
            if (m_tvalid && m_tready)
            begin
                words_checked++;
                if (expected_results.size() == 0)
                begin
                    $display("[%0t] unexpected result word %h / %h", $realtime, m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.interp_value)
                        report("interp_value", m_tdata[31:0], want.interp_value);
                    if (m_tuser !== want.status)
                        report("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[35:32] !== want.point_count)
                        report("point_count", 32'(m_tdata[35:32]), 32'(want.point_count));
                end
            end
        end
    end

endmodule

// ===== test/divided_difference_interpolator_tb.sv =====
`timescale 1ns / 1ps

module divided_difference_interpolator_tb;
    import ddi_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = REQ_APPEND;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    int fail_count, pending, words_checked, evals_checked, sat_seen, dup_seen;
    int words_sent;

    always #6 clk = ~clk;

    divided_difference_interpolator dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    ddi_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending), .words_checked(words_checked),
        .evals_checked(evals_checked), .sat_seen(sat_seen), .dup_seen(dup_seen)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_word(input logic [1:0] req, input logic [31:0] x, input logic [31:0] y);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {y, x};
        do @(posedge clk); while (!s_tready);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic idle_sender();
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] rand_abscissa(input int k);
        // distinct-ish small abscissas with fractional part, sometimes anything
        if ($urandom_range(0, 19) == 0)
            return $urandom();
        return 32'((k * 2 + $urandom_range(0, 1) - 8) <<< 16) + 32'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [31:0] rand_ordinate();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
    endfunction

    // receiver: one long hold-off early on, then random stalls
    initial
    begin
        int g;
        m_tready <= 1'b0;
        @(posedge rst_n);
        repeat (10) @(negedge clk);
        repeat (400) @(negedge clk);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 3) == 0)
            begin
                g = gap_len();
                m_tready <= (g == 0);
                if (g > 1)
                    repeat (g - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        #40ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int n;
        words_sent = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed
        send_word(REQ_EVAL, 32'h0001_0000, 32'h0);
        send_word(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(REQ_APPEND, 32'h0002_0000, 32'h0003_8000);
        send_word(REQ_EVAL, 32'h7FFF_FFFF, 32'h0);
        send_word(REQ_APPEND, 32'h0002_0000, 32'h0001_0000);
        send_word(REQ_EVAL, 32'h0001_0000, 32'h0);
        send_word(REQ_CLEAR, 32'h0, 32'h0);
        send_word(REQ_APPEND, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(REQ_APPEND, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(REQ_EVAL, 32'h0, 32'h0);
        send_word(REQ_EVAL, 32'h8000_0000, 32'h0);
        send_word(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int k = 0; k < DDI_MAX_POINTS; k++)
            send_word(REQ_APPEND, 32'(k <<< 16), 32'((k * k) <<< 16));
        send_word(REQ_APPEND, 32'h0009_0000, 32'h0);
        send_word(REQ_EVAL, 32'h0002_8000, 32'h0);
        send_word(REQ_EVAL, 32'h7FFF_FFFF, 32'h0);
        send_word(REQ_CLEAR, 32'h0, 32'h0);

        // random sets of points followed by queries
        while (words_sent < 420)
        begin
            if ($urandom_range(0, 19) == 0)
                send_word(2'($urandom_range(0, 3)), $urandom(), $urandom());
            else
            begin
                send_word(REQ_CLEAR, $urandom(), $urandom());
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 29) == 0)
                        send_word(REQ_APPEND, $urandom(), $urandom());
                    else
                        send_word(REQ_APPEND, rand_abscissa(k), rand_ordinate());
                    idle_sender();
                end
                repeat ($urandom_range(1, 3))
                begin
                    send_word(REQ_EVAL, ($urandom_range(0, 7) == 0) ? $urandom()
                              : rand_abscissa($urandom_range(0, 7)), $urandom());
                    idle_sender();
                end
            end
            idle_sender();
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);

        $display("sent %0d words, checked %0d results, %0d evaluations", words_sent,
                 words_checked, evals_checked);
        $display("saturated evaluations %0d, duplicate abscissa evaluations %0d", sat_seen,
                 dup_seen);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
